@@ rtl/core/vgd_pkg.sv @@
// shared codes and constants of the voxel grid downsample unit
`timescale 1ns / 1ps
package vgd_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [2:0] ST_MERGED = 3'd0;
  localparam logic [2:0] ST_NEW    = 3'd1;
  localparam logic [2:0] ST_DROP   = 3'd2;
  localparam logic [2:0] ST_RET    = 3'd3;
  localparam logic [2:0] ST_NONE   = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] EDGE_MM_RESET = 16'd500;
  localparam int QUEUE_DEPTH = 2;

  function automatic logic [31:0] hash_mul(input logic [1:0] axis);
    logic [31:0] m;
    case (axis)
      2'd0:    m = 32'd73856093;
      2'd1:    m = 32'd19349663;
      default: m = 32'd83492791;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/vgd_if.sv @@
// point and result channel interfaces
`timescale 1ns / 1ps
interface vgd_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic [31:0]                  point_var_x;
  logic [31:0]                  point_var_y;
  logic [31:0]                  point_var_z;
  modport source(output valid, command, point_x, point_y, point_z,
                 point_var_x, point_var_y, point_var_z, input ready);
  modport sink(input valid, command, point_x, point_y, point_z,
               point_var_x, point_var_y, point_var_z, output ready);
endinterface

interface vgd_out_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic signed [COORD_BITS-1:0] mean_x;
  logic signed [COORD_BITS-1:0] mean_y;
  logic signed [COORD_BITS-1:0] mean_z;
  logic [31:0]                  mean_var_x;
  logic [31:0]                  mean_var_y;
  logic [31:0]                  mean_var_z;
  logic [31:0]                  point_count;
  logic                         last;
  modport source(output valid, status, mean_x, mean_y, mean_z, mean_var_x,
                 mean_var_y, mean_var_z, point_count, last, input ready);
  modport sink(input valid, status, mean_x, mean_y, mean_z, mean_var_x,
               mean_var_y, mean_var_z, point_count, last, output ready);
endinterface

@@ rtl/core/voxel_grid_downsample_unit.sv @@
// top level of the voxel grid downsample unit
// channel   dir  handshake        payload
// in_ch     in   valid / ready    command, point_x/y/z, point_var_x/y/z
// out_ch    out  valid / ready    status, mean_x/y/z, mean_var_x/y/z, point_count, last
// cfg       in   cfg_we           cfg_wdata = voxel edge length in mm
// add: the front divides each coordinate by the edge for the keys, hashes them and forms
//   the home slot before the push, then the back table loop probes slot by slot
// read: scan to the next valid slot, six mean divisions, then scan on to the next valid slot for last
// clear: a sweep over all slots; after reset a sweep over all CAPACITY slots clears the valid ram,
//   in_ch.ready stays low meanwhile (cfg writes still taken)
// the job queue lets the front take new items while a result waits on out_ch
`timescale 1ns / 1ps
module voxel_grid_downsample_unit import vgd_pkg::*; #(
  parameter int CAPACITY   = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  vgd_in_if.sink      in_ch,
  vgd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  localparam int JW = 2 + 6 * COORD_BITS + 96 + $clog2(CAPACITY);

  logic [15:0]   edge_mm_r;
  logic          job_push;
  logic          job_full;
  logic          job_pop;
  logic          job_empty;
  logic [JW-1:0] job_in;
  logic [JW-1:0] job_out;
  logic          table_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) edge_mm_r <= EDGE_MM_RESET;
    else if (cfg_we) edge_mm_r <= cfg_wdata;
  end

  vgd_front #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .table_ready(table_ready),
    .edge_mm(edge_mm_r), .job_push(job_push), .job_data(job_in),
    .job_full(job_full)
  );

  vgd_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(job_push), .din(job_in), .full(job_full),
    .pop(job_pop), .dout(job_out), .empty(job_empty)
  );

  vgd_back #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_empty(job_empty), .job_data(job_out),
    .job_pop(job_pop), .table_ready(table_ready), .out_ch(out_ch)
  );
endmodule

@@ rtl/core/vgd_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module vgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/core/vgd_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module vgd_divider #(
  parameter int DW = 64,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fit;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fit   = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= CW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[DW-2:0], fit};
        rem_r <= fit ? diff[VW-1:0] : trial[VW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

@@ rtl/core/vgd_fifo.sv @@
// short job queue between front and back
`timescale 1ns / 1ps
module vgd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= bump(wp_r);
      if (pop && !empty) rp_r <= bump(rp_r);
      if ((push && !full) && !(pop && !empty)) cnt_r <= cnt_r + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

@@ rtl/core/vgd_front.sv @@
// front end: accepts commands, computes voxel keys and home slot
`timescale 1ns / 1ps
module vgd_front import vgd_pkg::*; #(
  parameter int CAPACITY   = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  vgd_in_if.sink               in_ch,
  input  logic                 table_ready,
  input  logic [15:0]          edge_mm,
  output logic                 job_push,
  output logic [2+6*COORD_BITS+96+$clog2(CAPACITY)-1:0] job_data,
  input  logic                 job_full
);
  localparam int CB  = COORD_BITS;
  localparam int SW  = $clog2(CAPACITY);
  localparam int FDW = (CB + 1 > 32) ? CB + 1 : 32;
  localparam int DVW = 16;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV, F_WAIT, F_MUL, F_XOR, F_HOME, F_PUSH
  } fstate_t;

  fstate_t              state_r;
  logic [1:0]           axis_r;
  logic [1:0]           cmd_r;
  logic signed [CB-1:0] px_r, py_r, pz_r;
  logic [31:0]          vx_r, vy_r, vz_r;
  logic signed [CB-1:0] key_r [3];
  logic [31:0]          prod_r;
  logic [31:0]          h_r;
  logic [SW-1:0]        home_r;

  logic signed [CB-1:0] coord;
  logic signed [FDW-1:0] coord_ext;
  logic [FDW-1:0]       mag;
  logic [CB:0]          uq;
  logic [CB:0]          q;
  logic [CB-1:0]        key_new;
  logic [15:0]          vs_eff;
  logic                 div_start;
  logic [FDW-1:0]       div_dividend;
  logic [DVW-1:0]       div_divisor;
  logic                 div_done;
  logic [FDW-1:0]       div_quo;
  logic [DVW-1:0]       div_rem;
  logic                 accept;

  always_comb begin
    case (axis_r)
      2'd0:    coord = px_r;
      2'd1:    coord = py_r;
      default: coord = pz_r;
    endcase
  end

  assign vs_eff       = (edge_mm == '0) ? 16'd1 : edge_mm;
  assign coord_ext    = FDW'(coord);
  assign mag          = coord[CB-1] ? FDW'(-coord_ext) : FDW'(coord_ext);
  assign div_start    = state_r == F_DIV;
  assign div_dividend = mag;
  assign div_divisor  = DVW'(vs_eff);

  // floor-like index with the extra step down for negative input
  assign uq      = div_quo[CB:0];
  assign q       = coord[CB-1] ? ~uq : uq;
  assign key_new = (q[CB] != q[CB-1]) ? {1'b1, {(CB-1){1'b0}}} : q[CB-1:0];

  vgd_divider #(.DW(FDW), .VW(DVW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  assign in_ch.ready = (state_r == F_IDLE) && table_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign job_push    = (state_r == F_PUSH) && !job_full;
  assign job_data    = {cmd_r, key_r[0], key_r[1], key_r[2], px_r, py_r, pz_r,
                        vx_r, vy_r, vz_r, home_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      axis_r  <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            cmd_r    <= in_ch.command;
            px_r     <= in_ch.point_x;
            py_r     <= in_ch.point_y;
            pz_r     <= in_ch.point_z;
            vx_r     <= in_ch.point_var_x;
            vy_r     <= in_ch.point_var_y;
            vz_r     <= in_ch.point_var_z;
            key_r[0] <= '0;
            key_r[1] <= '0;
            key_r[2] <= '0;
            home_r   <= '0;
            axis_r   <= '0;
            if (in_ch.command == CMD_ADD) state_r <= F_DIV;
            else if (in_ch.command == CMD_READ || in_ch.command == CMD_CLEAR)
              state_r <= F_PUSH;
          end
        end
        F_DIV: state_r <= F_WAIT;
        F_WAIT: begin
          if (div_done) begin
            key_r[axis_r] <= key_new;
            if (axis_r == 2'd2) begin
              axis_r  <= '0;
              h_r     <= '0;
              state_r <= F_MUL;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= F_DIV;
            end
          end
        end
        F_MUL: begin
          prod_r  <= 32'(key_r[axis_r]) * hash_mul(axis_r);
          state_r <= F_XOR;
        end
        F_XOR: begin
          h_r <= h_r ^ prod_r;
          if (axis_r == 2'd2) state_r <= F_HOME;
          else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= F_MUL;
          end
        end
        // power of two capacity, home slot is the low hash bits
        F_HOME: begin
          home_r  <= h_r[SW-1:0];
          state_r <= F_PUSH;
        end
        F_PUSH: if (!job_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/vgd_back.sv @@
// back end: table probing, merge, drain with means, clear sweep
`timescale 1ns / 1ps
module vgd_back import vgd_pkg::*; #(
  parameter int CAPACITY   = 4096,
  parameter int COORD_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_empty,
  input  logic [2+6*COORD_BITS+96+$clog2(CAPACITY)-1:0] job_data,
  output logic       job_pop,
  output logic       table_ready,
  vgd_out_if.source  out_ch
);
  localparam int CB   = COORD_BITS;
  localparam int SW   = $clog2(CAPACITY);
  localparam int JW   = 2 + 6 * CB + 96 + SW;
  localparam int SUMW = CB + 32;
  localparam int EW   = 3 * CB + 3 * SUMW + 3 * 64 + 32;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_ADD_RD, S_ADD_CHK, S_SCAN_RD, S_SCAN_CHK,
    S_DIV_GO, S_DIV_WAIT, S_LAST_RD, S_LAST_CHK, S_CLR, S_RESP
  } bstate_t;

  bstate_t       state_r;
  logic [JW-1:0] job_r;
  logic [SW-1:0] addr_r;
  logic [SW:0]   probe_r;
  logic [SW:0]   ptr_r;
  logic [EW-1:0] entry_r;
  logic [2:0]    idx_r;
  logic          neg_r;

  logic [2:0]           res_status_r;
  logic [CB-1:0]        res_mx_r, res_my_r, res_mz_r;
  logic [31:0]          res_vx_r, res_vy_r, res_vz_r;
  logic [31:0]          res_cnt_r;
  logic                 res_last_r;

  logic [1:0]           j_cmd;
  logic [CB-1:0]        j_kx, j_ky, j_kz;
  logic signed [CB-1:0] j_px, j_py, j_pz;
  logic [31:0]          j_vx, j_vy, j_vz;
  logic [SW-1:0]        j_home;

  logic [CB-1:0]   e_kx, e_ky, e_kz;
  logic [SUMW-1:0] e_sx, e_sy, e_sz;
  logic [63:0]     e_vx, e_vy, e_vz;
  logic [31:0]     e_cnt;
  logic [CB-1:0]   c_kx, c_ky, c_kz;
  logic [SUMW-1:0] c_sx, c_sy, c_sz;
  logic [63:0]     c_vx, c_vy, c_vz;
  logic [31:0]     c_cnt;

  logic            vld_rd;
  logic            vld_we;
  logic            vld_wdata;
  logic            ent_we;
  logic [EW-1:0]   ent_wdata;
  logic [EW-1:0]   ent_rd;
  logic [EW-1:0]   ent_new;
  logic [EW-1:0]   ent_merge;
  logic            match;
  logic [SW-1:0]   addr_inc;

  logic [SUMW-1:0]  sum_sel;
  logic signed [63:0] sum_ext;
  logic [63:0]     div_dividend;
  logic            div_done;
  logic [63:0]     div_quo;
  logic [31:0]     div_rem;
  logic [63:0]     q_signed;

  assign {j_cmd, j_kx, j_ky, j_kz, j_px, j_py, j_pz, j_vx, j_vy, j_vz, j_home} = job_r;
  assign {e_kx, e_ky, e_kz, e_sx, e_sy, e_sz, e_vx, e_vy, e_vz, e_cnt} = ent_rd;
  assign {c_kx, c_ky, c_kz, c_sx, c_sy, c_sz, c_vx, c_vy, c_vz, c_cnt} = entry_r;

  assign addr_inc = (addr_r == SW'(CAPACITY - 1)) ? '0 : addr_r + 1'b1;
  assign match    = (e_kx == j_kx) && (e_ky == j_ky) && (e_kz == j_kz);

  assign ent_new   = {j_kx, j_ky, j_kz, SUMW'(j_px), SUMW'(j_py), SUMW'(j_pz),
                      64'(j_vx), 64'(j_vy), 64'(j_vz), 32'd1};
  assign ent_merge = {e_kx, e_ky, e_kz, e_sx + SUMW'(j_px), e_sy + SUMW'(j_py),
                      e_sz + SUMW'(j_pz), e_vx + 64'(j_vx), e_vy + 64'(j_vy),
                      e_vz + 64'(j_vz), e_cnt + 32'd1};
  assign ent_wdata = vld_rd ? ent_merge : ent_new;
  assign ent_we    = (state_r == S_ADD_CHK) &&
                     (!vld_rd || (match && e_cnt != COUNT_MAX));
  assign vld_we    = (state_r == S_INIT) || (state_r == S_CLR) || ent_we;
  assign vld_wdata = state_r == S_ADD_CHK;

  vgd_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_valid (
    .clk(clk), .we(vld_we), .waddr(addr_r), .wdata(vld_wdata),
    .raddr(addr_r), .rdata(vld_rd)
  );

  vgd_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_entry (
    .clk(clk), .we(ent_we), .waddr(addr_r), .wdata(ent_wdata),
    .raddr(addr_r), .rdata(ent_rd)
  );

  always_comb begin
    case (idx_r)
      3'd0:    sum_sel = c_sx;
      3'd1:    sum_sel = c_sy;
      default: sum_sel = c_sz;
    endcase
  end

  assign sum_ext = 64'($signed(sum_sel));
  always_comb begin
    case (idx_r)
      3'd3:    div_dividend = c_vx;
      3'd4:    div_dividend = c_vy;
      3'd5:    div_dividend = c_vz;
      default: div_dividend = sum_sel[SUMW-1] ? 64'(-sum_ext) : 64'(sum_ext);
    endcase
  end

  vgd_divider #(.DW(64), .VW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DIV_GO),
    .dividend(div_dividend), .divisor(c_cnt), .done(div_done),
    .quotient(div_quo), .remainder(div_rem)
  );

  assign q_signed    = neg_r ? -div_quo : div_quo;
  assign job_pop     = (state_r == S_IDLE) && !job_empty;
  assign table_ready = state_r != S_INIT;

  assign out_ch.valid       = state_r == S_RESP;
  assign out_ch.status      = res_status_r;
  assign out_ch.mean_x      = res_mx_r;
  assign out_ch.mean_y      = res_my_r;
  assign out_ch.mean_z      = res_mz_r;
  assign out_ch.mean_var_x  = res_vx_r;
  assign out_ch.mean_var_y  = res_vy_r;
  assign out_ch.mean_var_z  = res_vz_r;
  assign out_ch.point_count = res_cnt_r;
  assign out_ch.last        = res_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      addr_r  <= '0;
      ptr_r   <= '0;
    end else begin
      case (state_r)
        S_INIT: begin
          addr_r <= addr_inc;
          if (addr_r == SW'(CAPACITY - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (!job_empty) begin
            job_r        <= job_data;
            res_mx_r     <= '0;
            res_my_r     <= '0;
            res_mz_r     <= '0;
            res_vx_r     <= '0;
            res_vy_r     <= '0;
            res_vz_r     <= '0;
            res_cnt_r    <= '0;
            res_last_r   <= 1'b0;
            state_r      <= S_DISP;
          end
        end
        S_DISP: begin
          case (j_cmd)
            CMD_ADD: begin
              addr_r  <= j_home;
              probe_r <= '0;
              state_r <= S_ADD_RD;
            end
            CMD_READ: begin
              if (ptr_r >= (SW + 1)'(CAPACITY)) begin
                res_status_r <= ST_NONE;
                state_r      <= S_RESP;
              end else begin
                addr_r  <= ptr_r[SW-1:0];
                state_r <= S_SCAN_RD;
              end
            end
            default: begin
              addr_r  <= '0;
              state_r <= S_CLR;
            end
          endcase
        end
        S_ADD_RD: state_r <= S_ADD_CHK;
        S_ADD_CHK: begin
          if (!vld_rd) begin
            res_status_r <= ST_NEW;
            state_r      <= S_RESP;
          end else if (match) begin
            res_status_r <= (e_cnt == COUNT_MAX) ? ST_DROP : ST_MERGED;
            state_r      <= S_RESP;
          end else if (probe_r == (SW + 1)'(CAPACITY - 1)) begin
            res_status_r <= ST_DROP;
            state_r      <= S_RESP;
          end else begin
            probe_r <= probe_r + 1'b1;
            addr_r  <= addr_inc;
            state_r <= S_ADD_RD;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (vld_rd) begin
            entry_r <= ent_rd;
            ptr_r   <= (SW + 1)'(addr_r) + 1'b1;
            idx_r   <= '0;
            state_r <= S_DIV_GO;
          end else if (addr_r == SW'(CAPACITY - 1)) begin
            ptr_r        <= (SW + 1)'(CAPACITY);
            res_status_r <= ST_NONE;
            state_r      <= S_RESP;
          end else begin
            addr_r  <= addr_inc;
            state_r <= S_SCAN_RD;
          end
        end
        S_DIV_GO: begin
          neg_r   <= (idx_r < 3'd3) && sum_sel[SUMW-1];
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (idx_r)
              3'd0:    res_mx_r <= q_signed[CB-1:0];
              3'd1:    res_my_r <= q_signed[CB-1:0];
              3'd2:    res_mz_r <= q_signed[CB-1:0];
              3'd3:    res_vx_r <= div_quo[31:0];
              3'd4:    res_vy_r <= div_quo[31:0];
              default: res_vz_r <= div_quo[31:0];
            endcase
            if (idx_r == 3'd5) begin
              res_status_r <= ST_RET;
              res_cnt_r    <= c_cnt;
              if (ptr_r == (SW + 1)'(CAPACITY)) begin
                res_last_r <= 1'b1;
                state_r    <= S_RESP;
              end else begin
                addr_r  <= ptr_r[SW-1:0];
                state_r <= S_LAST_RD;
              end
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_LAST_RD: state_r <= S_LAST_CHK;
        S_LAST_CHK: begin
          if (vld_rd) begin
            res_last_r <= 1'b0;
            state_r    <= S_RESP;
          end else if (addr_r == SW'(CAPACITY - 1)) begin
            res_last_r <= 1'b1;
            state_r    <= S_RESP;
          end else begin
            addr_r  <= addr_inc;
            state_r <= S_LAST_RD;
          end
        end
        S_CLR: begin
          addr_r <= addr_inc;
          if (addr_r == SW'(CAPACITY - 1)) begin
            ptr_r        <= '0;
            res_status_r <= ST_CLEAR;
            state_r      <= S_RESP;
          end
        end
        S_RESP: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= (SW + 1)'(CAPACITY))
    else $error("drain pointer past table end");

  a_ret_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_RET |-> out_ch.point_count != '0)
    else $error("returned voxel with zero count");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_RET |->
      out_ch.point_count == '0 && !out_ch.last && out_ch.mean_var_x == '0)
    else $error("non-return result carries voxel fields");

  a_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD_CHK && !vld_rd |=> state_r == S_RESP && res_status_r == ST_NEW)
    else $error("empty slot did not take the new voxel");
endmodule
